// ----- rtl/mlbb_pkg.sv -----
// Shared types and constants of the multi-list bounded buffer.
`timescale 1ns / 1ps
package mlbb_pkg;

   localparam int NUM_LISTS_DEF    = 10;
   localparam int MAX_CAPACITY_DEF = 16;
   localparam int VALUE_WIDTH_DEF  = 32;

   localparam int REQ_DATA_W = 48;   // slot, item_value, size_amount, zero fill
   localparam int RSP_DATA_W = 48;   // status, element_value, fill_count, zero fill

   // action codes
   localparam logic [3:0] ACT_CREATE = 4'd0;
   localparam logic [3:0] ACT_APPEND = 4'd1;
   localparam logic [3:0] ACT_POP    = 4'd2;
   localparam logic [3:0] ACT_DELETE = 4'd3;
   localparam logic [3:0] ACT_READ   = 4'd4;
   localparam logic [3:0] ACT_SORTED = 4'd5;
   localparam logic [3:0] ACT_RESIZE = 4'd6;
   localparam logic [3:0] ACT_COUNT  = 4'd7;
   localparam logic [3:0] ACT_CLEAR  = 4'd8;

   // status codes
   localparam logic [3:0] ST_OK           = 4'd0;
   localparam logic [3:0] ST_BAD_SLOT     = 4'd1;
   localparam logic [3:0] ST_BAD_SIZE     = 4'd2;
   localparam logic [3:0] ST_EXISTS       = 4'd3;
   localparam logic [3:0] ST_NO_MEMORY    = 4'd4;
   localparam logic [3:0] ST_FULL         = 4'd5;
   localparam logic [3:0] ST_NO_LIST      = 4'd6;
   localparam logic [3:0] ST_EMPTY        = 4'd7;
   localparam logic [3:0] ST_NOT_FOUND    = 4'd8;
   localparam logic [3:0] ST_BAD_NEW_SIZE = 4'd9;

   // controller to datapath
   typedef struct packed {
      logic capture;    // take the request item
      logic simple;     // commit a single-result command and emit its result
      logic start;      // reset walk pointers
      logic rd;         // read store at pointer
      logic rd_next;    // read store at pointer + 1
      logic ptr_inc;
      logic del_check;  // latch match flag
      logic shift_wr;   // write shifted element at pointer, advance
      logic del_fin;    // emit delete result, drop fill on hit
      logic rd_emit;    // emit element in stored order
      logic srt_check;  // compare element with best candidate
      logic srt_emit;   // emit best candidate
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;   // output register can take a result this cycle
      logic simple;
      logic go_del;
      logic go_rd;
      logic go_srt;
      logic match;      // read data equals the item value
      logic ptr_last;   // pointer is at the last element
      logic cnt_last;   // next sorted result is the final one
   } stat_type;

endpackage

// ----- rtl/multi_list_bounded_buffer.sv -----
// Top level of the multi-list bounded buffer: sequencer plus datapath.
// Order: a single-result command is captured, then decoded and its result
//   registered once the output register is free, and then the next item is taken;
//   delete reads and checks each element searched, then reads and writes each
//   element shifted; read reads and then emits each element. Throughput: one item
//   at a time; sorted read walks all n elements for each result, set by the single read port of the element store.
// Reset: synchronous, active high; clears all lists and the output register.
`timescale 1ns / 1ps
module multi_list_bounded_buffer #(
   parameter int NUM_LISTS    = mlbb_pkg::NUM_LISTS_DEF,
   parameter int MAX_CAPACITY = mlbb_pkg::MAX_CAPACITY_DEF,
   parameter int VALUE_WIDTH  = mlbb_pkg::VALUE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mlbb_pkg::REQ_DATA_W-1:0] req_tdata,  // slot[3:0], item_value[35:4],
                                                        // size_amount[44:36], zero
   input  logic [3:0]                      req_tuser,  // action
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mlbb_pkg::RSP_DATA_W-1:0] rsp_tdata,  // status[3:0], element_value[35:4],
                                                        // fill_count[40:36], zero
   output logic                            rsp_tuser,  // element_valid
   output logic                            rsp_tlast   // last result of this item
);

   mlbb_pkg::cmd_type  cmd;
   mlbb_pkg::stat_type stat;

   // Sequencer: decodes each item, walks the element store for delete,
   // read and sorted read, and paces results against the output register.
   mlbb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Datapath: per-list capacity/fill/exists tables, the element store,
   // sort trackers and the result register.
   mlbb_dp #(
      .NUM_LISTS    (NUM_LISTS),
      .MAX_CAPACITY (MAX_CAPACITY),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while an item is in work");

   // element results carry status ok and no fill count
   a_elem_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[3:0] == mlbb_pkg::ST_OK
                                 && rsp_tdata[40:36] == 5'd0)
      else $error("element result with bad status or fill");

   // non-element results carry a zero value
   a_no_elem_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[35:4] == 32'd0 && rsp_tlast)
      else $error("non-element result with value or without last");

endmodule

// ----- rtl/mlbb_ctrl.sv -----
// Command sequencer of the multi-list bounded buffer.
`timescale 1ns / 1ps
module mlbb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  mlbb_pkg::stat_type stat,
   output mlbb_pkg::cmd_type  cmd
);

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_DECODE   = 13'b0000000000010,
      S_DEL_RD   = 13'b0000000000100,
      S_DEL_CHK  = 13'b0000000001000,
      S_SHF_RD   = 13'b0000000010000,
      S_SHF_WR   = 13'b0000000100000,
      S_DEL_NEXT = 13'b0000001000000,
      S_DEL_FIN  = 13'b0000010000000,
      S_RD_RD    = 13'b0000100000000,
      S_RD_OUT   = 13'b0001000000000,
      S_SRT_RD   = 13'b0010000000000,
      S_SRT_CHK  = 13'b0100000000000,
      S_SRT_OUT  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.simple) begin
               if (stat.out_free) begin
                  cmd.simple = 1'b1;
                  state_in   = S_IDLE;
               end
            end else begin
               cmd.start = 1'b1;
               if (stat.go_del)      state_in = S_DEL_RD;
               else if (stat.go_rd)  state_in = S_RD_RD;
               else if (stat.go_srt) state_in = S_SRT_RD;
            end
         end
         S_DEL_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_DEL_CHK;
         end
         S_DEL_CHK: begin
            cmd.del_check = 1'b1;
            if (stat.ptr_last)   state_in = S_DEL_FIN;
            else if (stat.match) state_in = S_SHF_RD;
            else begin
               cmd.ptr_inc = 1'b1;
               state_in    = S_DEL_RD;
            end
         end
         S_SHF_RD: begin
            cmd.rd_next = 1'b1;
            state_in    = S_SHF_WR;
         end
         S_SHF_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_DEL_NEXT;
         end
         S_DEL_NEXT: begin
            state_in = stat.ptr_last ? S_DEL_FIN : S_SHF_RD;
         end
         S_DEL_FIN: begin
            if (stat.out_free) begin
               cmd.del_fin = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_RD_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_RD_OUT;
         end
         S_RD_OUT: begin
            if (stat.out_free) begin
               cmd.rd_emit = 1'b1;
               cmd.ptr_inc = 1'b1;
               state_in    = stat.ptr_last ? S_IDLE : S_RD_RD;
            end
         end
         S_SRT_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_SRT_CHK;
         end
         S_SRT_CHK: begin
            cmd.srt_check = 1'b1;
            cmd.ptr_inc   = 1'b1;
            state_in      = stat.ptr_last ? S_SRT_OUT : S_SRT_RD;
         end
         S_SRT_OUT: begin
            if (stat.out_free) begin
               cmd.srt_emit = 1'b1;
               state_in     = stat.cnt_last ? S_IDLE : S_SRT_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- rtl/mlbb_dp.sv -----
// Datapath: list tables, element store, walk registers and output register.
`timescale 1ns / 1ps
module mlbb_dp #(
   parameter int NUM_LISTS    = mlbb_pkg::NUM_LISTS_DEF,
   parameter int MAX_CAPACITY = mlbb_pkg::MAX_CAPACITY_DEF,
   parameter int VALUE_WIDTH  = mlbb_pkg::VALUE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mlbb_pkg::cmd_type               cmd,
   output mlbb_pkg::stat_type              stat,
   input  logic [mlbb_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [3:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mlbb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int PW = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
   localparam int CW = $clog2(MAX_CAPACITY + 1);
   localparam int AW = LW + PW;
   localparam int DEPTH = NUM_LISTS * (2 ** PW);
   localparam int VW = VALUE_WIDTH;

   // captured request
   logic [3:0]        action_ff;
   logic [3:0]        slot_ff;
   logic [31:0]       value_ff;
   logic signed [8:0] amount_ff;

   // list tables
   logic              exists_ff [NUM_LISTS];
   logic [CW-1:0]     cap_ff    [NUM_LISTS];
   logic [CW-1:0]     fill_ff   [NUM_LISTS];

   // element store
   logic [VW-1:0]     mem_ff [DEPTH];
   logic [VW-1:0]     rdata_ff;

   // walk state
   logic [CW-1:0]     ptr_ff, cnt_ff;
   logic              hit_ff;
   logic [VW-1:0]     prev_v_ff, best_v_ff;
   logic [CW-1:0]     prev_i_ff, best_i_ff;
   logic              have_prev_ff, have_best_ff;

   // output register
   logic              out_valid_ff;
   logic [3:0]        out_st_ff;
   logic              out_ev_ff;
   logic [31:0]       out_val_ff;
   logic [4:0]        out_fill_ff;
   logic              out_last_ff;

   logic              slot_ok;
   logic [LW-1:0]     idx;
   logic [CW-1:0]     n, cap, ptr_nx;
   logic [VW-1:0]     val_in;
   logic [63:0]       wide_in;
   logic signed [10:0] new_size;
   logic [3:0]        dec_st;
   logic [4:0]        dec_fill;
   logic              dec_simple, dec_del, dec_rd, dec_srt;
   logic              above_prev, below_best;
   logic              emit;
   logic [3:0]        emit_st;
   logic              emit_ev;
   logic [VW-1:0]     emit_v;
   logic [63:0]       emit_wide;
   logic              emit_last;
   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [VW-1:0]     wr_data;
   logic              rd_en;

   assign slot_ok  = (slot_ff != 4'd0) && (7'(slot_ff) <= 7'(NUM_LISTS));
   assign idx      = LW'(slot_ff - 4'd1);
   assign n        = fill_ff[idx];
   assign cap      = cap_ff[idx];
   assign ptr_nx   = ptr_ff + CW'(1);
   assign wide_in  = 64'(value_ff);
   assign val_in   = wide_in[VW-1:0];
   assign new_size = $signed(11'(cap)) + 11'(amount_ff);

   // command decode and checks (none for clear and unused actions), in the order slot, size, existence, own condition
   always_comb begin
      dec_st     = mlbb_pkg::ST_OK;
      dec_fill   = 5'd0;
      dec_simple = 1'b1;
      dec_del    = 1'b0;
      dec_rd     = 1'b0;
      dec_srt    = 1'b0;
      if (action_ff >= mlbb_pkg::ACT_CLEAR) begin
         dec_st = mlbb_pkg::ST_OK;
      end else if (!slot_ok) begin
         dec_st = mlbb_pkg::ST_BAD_SLOT;
      end else if (action_ff == mlbb_pkg::ACT_CREATE) begin
         if (amount_ff < 9'sd1)                                dec_st = mlbb_pkg::ST_BAD_SIZE;
         else if (exists_ff[idx])                              dec_st = mlbb_pkg::ST_EXISTS;
         else if (amount_ff > $signed(9'(MAX_CAPACITY)))       dec_st = mlbb_pkg::ST_NO_MEMORY;
      end else if (!exists_ff[idx]) begin
         dec_st = mlbb_pkg::ST_NO_LIST;
      end else begin
         case (action_ff)
            mlbb_pkg::ACT_APPEND:
               if (n >= cap || n >= CW'(MAX_CAPACITY)) dec_st = mlbb_pkg::ST_FULL;
            mlbb_pkg::ACT_POP:
               if (n == '0) dec_st = mlbb_pkg::ST_EMPTY;
            mlbb_pkg::ACT_DELETE: begin
               if (n == '0) dec_st = mlbb_pkg::ST_EMPTY;
               else begin
                  dec_simple = 1'b0;
                  dec_del    = 1'b1;
               end
            end
            mlbb_pkg::ACT_READ, mlbb_pkg::ACT_SORTED: begin
               if (n != '0) begin
                  dec_simple = 1'b0;
                  dec_rd     = (action_ff == mlbb_pkg::ACT_READ);
                  dec_srt    = (action_ff == mlbb_pkg::ACT_SORTED);
               end
            end
            mlbb_pkg::ACT_RESIZE: begin
               if (new_size < 11'sd1)                          dec_st = mlbb_pkg::ST_BAD_NEW_SIZE;
               else if (new_size > $signed(11'(MAX_CAPACITY))) dec_st = mlbb_pkg::ST_NO_MEMORY;
            end
            mlbb_pkg::ACT_COUNT: begin
               if (n == '0) dec_st = mlbb_pkg::ST_EMPTY;
               else         dec_fill = 5'(n);
            end
            default: dec_st = mlbb_pkg::ST_OK;
         endcase
      end
   end

   // (value, position) order: signed value first, stored position breaks ties
   assign above_prev = !have_prev_ff || ($signed(rdata_ff) > $signed(prev_v_ff)) ||
                       ((rdata_ff == prev_v_ff) && (ptr_ff > prev_i_ff));
   assign below_best = !have_best_ff || ($signed(rdata_ff) < $signed(best_v_ff)) ||
                       ((rdata_ff == best_v_ff) && (ptr_ff < best_i_ff));

   assign stat.out_free = !out_valid_ff || rsp_tready;
   assign stat.simple   = dec_simple;
   assign stat.go_del   = dec_del;
   assign stat.go_rd    = dec_rd;
   assign stat.go_srt   = dec_srt;
   assign stat.match    = (rdata_ff == val_in);
   assign stat.ptr_last = (ptr_nx == n);
   assign stat.cnt_last = ((cnt_ff + CW'(1)) == n);

   // store ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {idx, n[PW-1:0]};
      wr_data = val_in;
      if (cmd.simple && action_ff == mlbb_pkg::ACT_APPEND && dec_st == mlbb_pkg::ST_OK)
         wr_en = 1'b1;
      if (cmd.shift_wr) begin
         wr_en   = 1'b1;
         wr_addr = {idx, ptr_ff[PW-1:0]};
         wr_data = rdata_ff;
      end
   end

   assign rd_en   = cmd.rd || cmd.rd_next;
   assign rd_addr = cmd.rd_next ? {idx, ptr_nx[PW-1:0]} : {idx, ptr_ff[PW-1:0]};

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem_ff[rd_addr];
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_tuser;
         slot_ff   <= req_tdata[3:0];
         value_ff  <= req_tdata[35:4];
         amount_ff <= $signed(req_tdata[44:36]);
      end
   end

   // list tables
   always_ff @(posedge clock) begin
      if (reset || (cmd.simple && action_ff == mlbb_pkg::ACT_CLEAR)) begin
         for (int i = 0; i < NUM_LISTS; i++) begin
            exists_ff[i] <= 1'b0;
            cap_ff[i]    <= '0;
            fill_ff[i]   <= '0;
         end
      end else if (cmd.simple && dec_st == mlbb_pkg::ST_OK && slot_ok) begin
         case (action_ff)
            mlbb_pkg::ACT_CREATE: begin
               exists_ff[idx] <= 1'b1;
               cap_ff[idx]    <= CW'(amount_ff);
               fill_ff[idx]   <= '0;
            end
            mlbb_pkg::ACT_APPEND: fill_ff[idx] <= n + CW'(1);
            mlbb_pkg::ACT_POP:    fill_ff[idx] <= n - CW'(1);
            mlbb_pkg::ACT_RESIZE: begin
               cap_ff[idx] <= CW'(new_size);
               if (n > CW'(new_size)) fill_ff[idx] <= CW'(new_size);
            end
            default: ;
         endcase
      end else if (cmd.del_fin && hit_ff) begin
         fill_ff[idx] <= n - CW'(1);
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         have_prev_ff <= 1'b0;
         have_best_ff <= 1'b0;
      end else begin
         if (cmd.ptr_inc || cmd.shift_wr) ptr_ff <= ptr_nx;
         if (cmd.del_check) hit_ff <= stat.match;
         if (cmd.srt_check && above_prev && below_best) begin
            best_v_ff    <= rdata_ff;
            best_i_ff    <= ptr_ff;
            have_best_ff <= 1'b1;
         end
         if (cmd.srt_emit) begin
            prev_v_ff    <= best_v_ff;
            prev_i_ff    <= best_i_ff;
            have_prev_ff <= 1'b1;
            have_best_ff <= 1'b0;
            ptr_ff       <= '0;
            cnt_ff       <= cnt_ff + CW'(1);
         end
      end
   end

   // result selection
   always_comb begin
      emit      = cmd.simple || cmd.del_fin || cmd.rd_emit || cmd.srt_emit;
      emit_st   = mlbb_pkg::ST_OK;
      emit_ev   = 1'b0;
      emit_v    = '0;
      emit_last = 1'b1;
      if (cmd.simple) begin
         emit_st = dec_st;
      end else if (cmd.del_fin) begin
         emit_st = hit_ff ? mlbb_pkg::ST_OK : mlbb_pkg::ST_NOT_FOUND;
      end else if (cmd.rd_emit) begin
         emit_ev   = 1'b1;
         emit_v    = rdata_ff;
         emit_last = stat.ptr_last;
      end else if (cmd.srt_emit) begin
         emit_ev   = 1'b1;
         emit_v    = best_v_ff;
         emit_last = stat.cnt_last;
      end
      emit_wide = 64'(emit_v);
   end

   always_ff @(posedge clock) begin
      if (reset)          out_valid_ff <= 1'b0;
      else if (emit)      out_valid_ff <= 1'b1;
      else if (rsp_tready) out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_st_ff   <= emit_st;
         out_ev_ff   <= emit_ev;
         out_val_ff  <= emit_wide[31:0];
         out_fill_ff <= cmd.simple ? dec_fill : 5'd0;
         out_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_fill_ff, out_val_ff, out_st_ff};
   assign rsp_tuser  = out_ev_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- sim/multi_list_bounded_buffer_tb.sv -----
// Self-checking testbench of the multi-list bounded buffer.
`timescale 1ns / 1ps
module multi_list_bounded_buffer_tb;

   localparam int NL = mlbb_pkg::NUM_LISTS_DEF;
   localparam int MC = mlbb_pkg::MAX_CAPACITY_DEF;

   typedef struct packed {
      logic [3:0]  status;
      logic        elem_ok;
      logic [31:0] elem;
      logic [4:0]  fill;
      logic        last;
   } result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [mlbb_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [3:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [mlbb_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   multi_list_bounded_buffer dut (.*);

   always #5 clock = ~clock;

   // shadow of the lists
   logic [31:0] lists_mem [NL][MC];
   int          lists_cap [NL];
   int          lists_fill [NL];
   bit          lists_live [NL];

   result_type pending_results[$];
   int errors = 0;
   int send_idle = 0;  // percent
   int recv_idle = 0;

   task automatic push_single(logic [3:0] st, int fl);
      result_type r;
      r = '{status: st, elem_ok: 1'b0, elem: '0, fill: fl[4:0], last: 1'b1};
      pending_results.push_back(r);
   endtask

   task automatic clear_lists();
      for (int i = 0; i < NL; i++) begin
         lists_cap[i] = 0;
         lists_fill[i] = 0;
         lists_live[i] = 0;
      end
   endtask

   // predicted response of one command
   task automatic predict_command(logic [3:0] act, logic [3:0] slot, logic [31:0] v,
                                  logic signed [8:0] amt);
      int idx, n, i, j, ns;
      logic [31:0] buf_v [MC];
      logic [31:0] t;
      result_type r;
      if (act == mlbb_pkg::ACT_CLEAR) begin
         clear_lists();
         push_single(mlbb_pkg::ST_OK, 0);
         return;
      end
      if (act > mlbb_pkg::ACT_CLEAR) begin
         push_single(mlbb_pkg::ST_OK, 0);
         return;
      end
      if (slot < 1 || slot > NL) begin
         push_single(mlbb_pkg::ST_BAD_SLOT, 0);
         return;
      end
      idx = slot - 1;
      if (act == mlbb_pkg::ACT_CREATE) begin
         if (amt < 1) push_single(mlbb_pkg::ST_BAD_SIZE, 0);
         else if (lists_live[idx]) push_single(mlbb_pkg::ST_EXISTS, 0);
         else if (amt > MC) push_single(mlbb_pkg::ST_NO_MEMORY, 0);
         else begin
            lists_live[idx] = 1;
            lists_cap[idx] = amt;
            lists_fill[idx] = 0;
            push_single(mlbb_pkg::ST_OK, 0);
         end
         return;
      end
      if (!lists_live[idx]) begin
         push_single(mlbb_pkg::ST_NO_LIST, 0);
         return;
      end
      n = lists_fill[idx];
      case (act)
         mlbb_pkg::ACT_APPEND: begin
            if (n >= lists_cap[idx]) push_single(mlbb_pkg::ST_FULL, 0);
            else begin
               lists_mem[idx][n] = v;
               lists_fill[idx] = n + 1;
               push_single(mlbb_pkg::ST_OK, 0);
            end
         end
         mlbb_pkg::ACT_POP: begin
            if (n == 0) push_single(mlbb_pkg::ST_EMPTY, 0);
            else begin
               lists_fill[idx] = n - 1;
               push_single(mlbb_pkg::ST_OK, 0);
            end
         end
         mlbb_pkg::ACT_DELETE: begin
            if (n == 0) push_single(mlbb_pkg::ST_EMPTY, 0);
            else begin
               for (i = 0; i < n; i++)
                  if (lists_mem[idx][i] == v) break;
               if (i == n) push_single(mlbb_pkg::ST_NOT_FOUND, 0);
               else begin
                  for (; i + 1 < n; i++) lists_mem[idx][i] = lists_mem[idx][i+1];
                  lists_fill[idx] = n - 1;
                  push_single(mlbb_pkg::ST_OK, 0);
               end
            end
         end
         mlbb_pkg::ACT_READ, mlbb_pkg::ACT_SORTED: begin
            if (n == 0) push_single(mlbb_pkg::ST_OK, 0);
            else begin
               for (i = 0; i < n; i++) buf_v[i] = lists_mem[idx][i];
               if (act == mlbb_pkg::ACT_SORTED)
                  for (i = 1; i < n; i++) begin
                     t = buf_v[i];
                     j = i;
                     while (j > 0 && $signed(buf_v[j-1]) > $signed(t)) begin
                        buf_v[j] = buf_v[j-1];
                        j--;
                     end
                     buf_v[j] = t;
                  end
               for (i = 0; i < n; i++) begin
                  r = '{status: mlbb_pkg::ST_OK, elem_ok: 1'b1, elem: buf_v[i], fill: 5'd0,
                        last: (i == n - 1)};
                  pending_results.push_back(r);
               end
            end
         end
         mlbb_pkg::ACT_RESIZE: begin
            ns = lists_cap[idx] + int'(amt);
            if (ns < 1) push_single(mlbb_pkg::ST_BAD_NEW_SIZE, 0);
            else if (ns > MC) push_single(mlbb_pkg::ST_NO_MEMORY, 0);
            else begin
               lists_cap[idx] = ns;
               if (lists_fill[idx] > ns) lists_fill[idx] = ns;
               push_single(mlbb_pkg::ST_OK, 0);
            end
         end
         default: begin  // count
            if (n == 0) push_single(mlbb_pkg::ST_EMPTY, 0);
            else push_single(mlbb_pkg::ST_OK, n);
         end
      endcase
   endtask

   // valid stays high after an accept; idle cycles and drain() drop it
   task automatic send_command(logic [3:0] act, logic [3:0] slot, logic [31:0] v,
                               logic signed [8:0] amt);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      predict_command(act, slot, v, amt);
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {3'b0, amt, v, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // receiver stalls
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // result checker
   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{status: rsp_tdata[3:0], elem_ok: rsp_tuser, elem: rsp_tdata[35:4],
                 fill: rsp_tdata[40:36], last: rsp_tlast};
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(7) - 3;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_command(mlbb_pkg::ACT_APPEND, 4'd0, 0, 0);            // bad slot
      send_command(mlbb_pkg::ACT_APPEND, 4'd15, 0, 0);
      send_command(mlbb_pkg::ACT_CREATE, 4'd1, 0, 9'sd0);        // bad size
      send_command(mlbb_pkg::ACT_CREATE, 4'd1, 0, -9'sd256);
      send_command(mlbb_pkg::ACT_CREATE, 4'd1, 0, 9'sd17);       // no memory
      send_command(mlbb_pkg::ACT_POP, 4'd2, 0, 0);               // no list
      send_command(mlbb_pkg::ACT_CREATE, 4'd1, 0, 9'sd2);
      send_command(mlbb_pkg::ACT_CREATE, 4'd1, 0, 9'sd2);        // exists
      send_command(mlbb_pkg::ACT_COUNT, 4'd1, 0, 0);             // empty
      send_command(mlbb_pkg::ACT_READ, 4'd1, 0, 0);              // empty read
      send_command(mlbb_pkg::ACT_POP, 4'd1, 0, 0);
      send_command(mlbb_pkg::ACT_DELETE, 4'd1, 0, 0);
      send_command(mlbb_pkg::ACT_APPEND, 4'd1, 32'h7fff_ffff, 0);
      send_command(mlbb_pkg::ACT_APPEND, 4'd1, 32'h8000_0000, 0);
      send_command(mlbb_pkg::ACT_APPEND, 4'd1, 32'h1, 0);         // full
      send_command(mlbb_pkg::ACT_SORTED, 4'd1, 0, 0);
      send_command(mlbb_pkg::ACT_DELETE, 4'd1, 32'h5, 0);         // not found
      send_command(mlbb_pkg::ACT_RESIZE, 4'd1, 0, -9'sd2);        // bad new size
      send_command(mlbb_pkg::ACT_RESIZE, 4'd1, 0, 9'sd255);       // no memory
      send_command(mlbb_pkg::ACT_RESIZE, 4'd1, 0, -9'sd1);        // clip fill
      send_command(mlbb_pkg::ACT_CREATE, 4'd10, 0, 9'sd16);
      send_command(mlbb_pkg::ACT_COUNT, 4'd1, 0, 0);
      send_command(4'd15, 4'd3, 32'hffff_ffff, 9'h1ff);           // unused action
      send_command(mlbb_pkg::ACT_CLEAR, 4'd7, 0, 0);
      send_command(mlbb_pkg::ACT_READ, 4'd10, 0, 0);
   endtask

   task automatic test_random(int count);
      logic [3:0] act, slot;
      int idx, k;
      for (int i = 0; i < count; i++) begin
         slot = 4'($urandom_range(1, NL));
         idx = slot - 1;
         k = $urandom_range(99);
         if (k < 3) slot = 4'($urandom_range(15));
         if (k < 6) act = 4'($urandom_range(15));
         else if (k < 8) act = mlbb_pkg::ACT_CLEAR;
         else if (!lists_live[idx]) act = mlbb_pkg::ACT_CREATE;
         else if (k < 45) act = mlbb_pkg::ACT_APPEND;
         else if (k < 55) act = mlbb_pkg::ACT_DELETE;
         else if (k < 65) act = mlbb_pkg::ACT_READ;
         else if (k < 75) act = mlbb_pkg::ACT_SORTED;
         else if (k < 82) act = mlbb_pkg::ACT_POP;
         else if (k < 90) act = mlbb_pkg::ACT_RESIZE;
         else if (k < 95) act = mlbb_pkg::ACT_COUNT;
         else act = mlbb_pkg::ACT_CREATE;
         if (act == mlbb_pkg::ACT_DELETE && lists_fill[idx] > 0 && $urandom_range(1))
            send_command(act, slot, lists_mem[idx][$urandom_range(lists_fill[idx]-1)],
                         9'($urandom));
         else if (act == mlbb_pkg::ACT_CREATE || act == mlbb_pkg::ACT_RESIZE)
            send_command(act, slot, $urandom,
                         $urandom_range(3) == 0 ? 9'($urandom)
                                                : 9'($urandom_range(20) - 4));
         else
            send_command(act, slot, pick_value(), 9'($urandom));
      end
   endtask

   initial begin
      clear_lists();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle = 10;
      recv_idle = 53;
      test_directed();
      test_random(100);
      drain();
      send_idle = 53;
      recv_idle = 10;
      test_random(100);
      drain();
      send_idle = 0;
      recv_idle = 0;
      test_random(85);
      drain();
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
